FILE: hdl/acd_pkg.sv
`default_nettype none

package acd_pkg;

    localparam int MAX_STAGES       = 128;
    localparam int STAGE_W          = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W            = $clog2(MAX_STAGES + 1);
    localparam int SAMPLE_W         = 24;
    localparam int STORE_W          = 26;
    localparam int WIDE_W           = STORE_W + 1;
    // one store row per stage: {phase, entry 1, entry 0}
    localparam int ROW_W            = 2 * STORE_W + 1;
    localparam int CFG_W            = 8;
    localparam int NUM_STAGES_RESET = 16;

    // controller to datapath
    typedef struct packed {
        logic               load_in;
        logic               issue;
        logic [STAGE_W-1:0] stage;
        logic               proc;
        logic               load_out;
    } acd_cmd_t;

    // raw register value to active stage count: zero acts as one, top clamps
    function automatic logic [CNT_W-1:0] clamp_stages(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (int'(v) > MAX_STAGES)
            r = CNT_W'(MAX_STAGES);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/acd_ram.sv
`default_nettype none

module acd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/acd_ctrl.sv
`default_nettype none

module acd_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [acd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output acd_pkg::acd_cmd_t               cmd
);

    import acd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] num_stages_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.stage      = cnt_reg[STAGE_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    n_next      = clamp_stages(num_stages_reg);
                    cnt_next    = '0;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                // read for stage cnt, finish stage cnt-1 as its entry arrives
                cmd.issue = (cnt_reg < n_reg);
                cmd.proc  = (cnt_reg != '0);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == n_reg)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_stages_reg <= CFG_W'(NUM_STAGES_RESET);
            n_reg          <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                num_stages_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/acd_datapath.sv
`default_nettype none

module acd_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire acd_pkg::acd_cmd_t                    cmd,
    input  wire logic signed [acd_pkg::SAMPLE_W-1:0]  sample_in,
    output logic signed      [acd_pkg::SAMPLE_W-1:0]  sample_out
);

    import acd_pkg::*;

    logic [MAX_STAGES-1:0]       written_reg;
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [SAMPLE_W-1:0]  out_reg;
    logic [STAGE_W-1:0]          stage_q_reg;
    logic                        hit_q_reg;

    logic [ROW_W-1:0]            rd_row;
    logic [ROW_W-1:0]            row;
    logic [ROW_W-1:0]            wr_row;
    logic                        phase;
    logic signed [STORE_W-1:0]   d;
    logic signed [WIDE_W-1:0]    yfull;
    logic signed [WIDE_W-1:0]    wfull;
    logic signed [SAMPLE_W-1:0]  y_sat;
    logic signed [STORE_W-1:0]   w_sat;

    acd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_STAGES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.proc),
        .waddr (stage_q_reg),
        .wdata (wr_row),
        .re    (cmd.issue),
        .raddr (cmd.stage),
        .rdata (rd_row)
    );

    // a never-written row reads as zero, phase bit included
    assign row   = hit_q_reg ? rd_row : '0;
    assign phase = row[ROW_W-1];
    assign d     = phase ? $signed(row[2*STORE_W-1:STORE_W]) : $signed(row[STORE_W-1:0]);
    assign yfull = WIDE_W'(d) - WIDE_W'(x_reg >>> 1);
    assign wfull = WIDE_W'(x_reg) + (yfull >>> 1);

    always_comb
    begin
        if (yfull[WIDE_W-1:SAMPLE_W-1] == '0 || yfull[WIDE_W-1:SAMPLE_W-1] == '1)
            y_sat = yfull[SAMPLE_W-1:0];
        else if (yfull[WIDE_W-1])
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};

        if (wfull[WIDE_W-1] == wfull[STORE_W-1])
            w_sat = wfull[STORE_W-1:0];
        else if (wfull[WIDE_W-1])
            w_sat = {1'b1, {(STORE_W-1){1'b0}}};
        else
            w_sat = {1'b0, {(STORE_W-1){1'b1}}};

        // update the entry just used and flip the phase
        wr_row          = row;
        wr_row[ROW_W-1] = ~phase;
        if (phase)
            wr_row[2*STORE_W-1:STORE_W] = w_sat;
        else
            wr_row[STORE_W-1:0] = w_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            written_reg <= '0;
        else if (cmd.proc)
            written_reg[stage_q_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            stage_q_reg <= cmd.stage;
            hit_q_reg   <= written_reg[cmd.stage];
        end
        if (cmd.load_in)
            x_reg <= sample_in;
        else if (cmd.proc)
            x_reg <= y_sat;
        if (cmd.load_out)
            out_reg <= x_reg;
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

FILE: hdl/allpass_cascade_disperser.sv
`default_nettype none

// channel   | beat signals            | payload
// ----------+-------------------------+-------------------------------
// input     | in_valid / in_ready     | sample_in   (24b signed Q1.23)
// output    | out_valid / out_ready   | sample_out  (24b signed Q1.23)
// config    | cfg_wr_en               | cfg_wr_data (8b num_stages)
//
// A sample is accepted, then runs through n stages, n the clamped stage count
// (1..128), one stage per cycle through the delay RAM (one row per stage
// holding both entries and the phase bit), with the RAM read registered;
// the result is then loaded into the output register.
// Reset clears the per-stage written flags; no clear sweep.
// A finished sample waits in the output register; the next input beat is
// taken meanwhile, and its result waits only if that register is still full.

module allpass_cascade_disperser (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [acd_pkg::CFG_W-1:0]            cfg_wr_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [acd_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [acd_pkg::SAMPLE_W-1:0]  sample_out
);

    import acd_pkg::*;

    acd_cmd_t cmd;

    acd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd)
    );

    acd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire
